// ----- src/mrrs_pkg.sv -----
package mrrs_pkg;

    localparam int NUM_SLOTS  = 16;
    localparam int NUM_LEVELS = 8;
    localparam int SLOT_W     = 4;
    localparam int LVL_W      = 3;
    localparam int CNT_W      = 5;
    localparam int QADDR_W    = LVL_W + SLOT_W;
    localparam int QDEPTH     = NUM_LEVELS * NUM_SLOTS;

    localparam logic [7:0] INIT_SLICE_FIRST = 8'd20;
    localparam logic [7:0] INIT_SLICE_IDLE  = 8'd1;

    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_RUN,
        OP_SLEEP,
        OP_SWITCH
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK,
        STAT_NO_SLOT,
        STAT_FULL,
        STAT_IGNORED
    } status_t;

    typedef enum logic [1:0] {
        SLOT_FREE,
        SLOT_ALLOC,
        SLOT_RUNNABLE
    } slot_state_t;

    typedef enum logic [4:0] {
        S_INIT0,
        S_INIT1,
        S_IDLE,
        S_ALLOC,
        S_RUN,
        S_DQ0,
        S_DQ_RD,
        S_DQ_CMP,
        S_SH_RD,
        S_SH_WR,
        S_ENQ,
        S_SLP1,
        S_SLP2,
        S_SLP3,
        S_SW1,
        S_SW2,
        S_SW3,
        S_SW4,
        S_DONE
    } fsm_t;

endpackage

// ----- src/mrrs_ram.sv -----
module mrrs_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/multilevel_round_robin_scheduler.sv -----
// The cost of run and sleep is set by the queue memory port: search and compaction
// of a level queue move one entry at a time, each entry through a read state and
// then a compare or write state. One item at a time; the next item is taken once
// the result is handed to the output register.
// Reset: asynchronous; after reset S_INIT0 and S_INIT1 write the two initial queue
// entries, and the block takes no item until then.
module multilevel_round_robin_scheduler
    import mrrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [1:0]  operation,
    input  logic [3:0]  task_id,
    input  logic signed [3:0] target_level,
    input  logic [7:0]  time_slice,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [3:0]  current_task,
    output logic [2:0]  current_level,
    output logic [7:0]  next_slice,
    output logic [3:0]  alloc_slot,
    output logic        yield_request,
    output logic [1:0]  status
);

    fsm_t state_reg, state_next;

    slot_state_t        slot_state_reg [NUM_SLOTS];
    logic [LVL_W-1:0]   slot_level_reg [NUM_SLOTS];
    logic [7:0]         slot_slice_reg [NUM_SLOTS];
    logic [CNT_W-1:0]   level_count_reg [NUM_LEVELS];
    logic [SLOT_W-1:0]  level_pos_reg [NUM_LEVELS];

    logic [LVL_W-1:0]   serving_reg, serving_next;
    logic               recheck_reg, recheck_next;
    logic [SLOT_W-1:0]  running_reg, running_next;

    op_t                op_reg, op_next;
    logic [SLOT_W-1:0]  t_reg, t_next;
    logic [3:0]         lraw_reg, lraw_next;
    logic [7:0]         slice_reg, slice_next;
    logic [LVL_W-1:0]   lv_reg, lv_next;
    logic [LVL_W-1:0]   dq_lv_reg, dq_lv_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   pos_reg, pos_next;
    logic [CNT_W-1:0]   nx_reg, nx_next;
    logic [SLOT_W-1:0]  head_task_reg, head_task_next;
    logic               ret_enq_reg, ret_enq_next;

    logic [7:0]         res_slice_reg, res_slice_next;
    logic [SLOT_W-1:0]  res_alloc_reg, res_alloc_next;
    logic               res_yield_reg, res_yield_next;
    status_t            res_status_reg, res_status_next;

    logic               rsp_valid_reg, rsp_valid_next;
    logic [3:0]         o_task_reg, o_task_next;
    logic [2:0]         o_level_reg, o_level_next;
    logic [7:0]         o_slice_reg, o_slice_next;
    logic [3:0]         o_alloc_reg, o_alloc_next;
    logic               o_yield_reg, o_yield_next;
    status_t            o_status_reg, o_status_next;

    logic [SLOT_W-1:0]  sidx;
    logic [LVL_W-1:0]   lidx;
    logic               ss_we, sl_we, sc_we;
    slot_state_t        ss_wd;
    logic [LVL_W-1:0]   sl_wd;
    logic               lc_we, lp_we;
    logic [CNT_W-1:0]   lc_wd;
    logic [SLOT_W-1:0]  lp_wd;

    logic               q_we;
    logic [QADDR_W-1:0] q_waddr, q_raddr;
    logic [SLOT_W-1:0]  q_wdata, q_rdata;

    logic [LVL_W-1:0]   best_level;
    logic [3:0]         lv4;
    logic               runnable, moving, adding;
    logic [CNT_W-1:0]   p_tmp, n_tmp, c_tmp;

    mrrs_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    always_comb
    begin
        best_level = LVL_W'(NUM_LEVELS - 1);
        for (int i = NUM_LEVELS - 1; i >= 0; i--)
        begin
            if (level_count_reg[i] != '0)
            begin
                best_level = LVL_W'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT0;
            serving_reg   <= '0;
            recheck_reg   <= 1'b1;
            running_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                slot_state_reg[i] <= SLOT_FREE;
                slot_level_reg[i] <= '0;
                slot_slice_reg[i] <= '0;
            end
            slot_state_reg[0] <= SLOT_RUNNABLE;
            slot_slice_reg[0] <= INIT_SLICE_FIRST;
            slot_state_reg[1] <= SLOT_RUNNABLE;
            slot_level_reg[1] <= LVL_W'(NUM_LEVELS - 1);
            slot_slice_reg[1] <= INIT_SLICE_IDLE;
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                level_count_reg[i] <= '0;
                level_pos_reg[i]   <= '0;
            end
            level_count_reg[0]              <= CNT_W'(1);
            level_count_reg[NUM_LEVELS - 1] <= CNT_W'(1);
        end
        else
        begin
            state_reg     <= state_next;
            serving_reg   <= serving_next;
            recheck_reg   <= recheck_next;
            running_reg   <= running_next;
            rsp_valid_reg <= rsp_valid_next;
            if (ss_we)
            begin
                slot_state_reg[sidx] <= ss_wd;
            end
            if (sl_we)
            begin
                slot_level_reg[sidx] <= sl_wd;
            end
            if (sc_we)
            begin
                slot_slice_reg[sidx] <= slice_reg;
            end
            if (lc_we)
            begin
                level_count_reg[lidx] <= lc_wd;
            end
            if (lp_we)
            begin
                level_pos_reg[lidx] <= lp_wd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        t_reg          <= t_next;
        lraw_reg       <= lraw_next;
        slice_reg      <= slice_next;
        lv_reg         <= lv_next;
        dq_lv_reg      <= dq_lv_next;
        idx_reg        <= idx_next;
        cnt_reg        <= cnt_next;
        pos_reg        <= pos_next;
        nx_reg         <= nx_next;
        head_task_reg  <= head_task_next;
        ret_enq_reg    <= ret_enq_next;
        res_slice_reg  <= res_slice_next;
        res_alloc_reg  <= res_alloc_next;
        res_yield_reg  <= res_yield_next;
        res_status_reg <= res_status_next;
        o_task_reg     <= o_task_next;
        o_level_reg    <= o_level_next;
        o_slice_reg    <= o_slice_next;
        o_alloc_reg    <= o_alloc_next;
        o_yield_reg    <= o_yield_next;
        o_status_reg   <= o_status_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        serving_next    = serving_reg;
        recheck_next    = recheck_reg;
        running_next    = running_reg;
        op_next         = op_reg;
        t_next          = t_reg;
        lraw_next       = lraw_reg;
        slice_next      = slice_reg;
        lv_next         = lv_reg;
        dq_lv_next      = dq_lv_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        pos_next        = pos_reg;
        nx_next         = nx_reg;
        head_task_next  = head_task_reg;
        ret_enq_next    = ret_enq_reg;
        res_slice_next  = res_slice_reg;
        res_alloc_next  = res_alloc_reg;
        res_yield_next  = res_yield_reg;
        res_status_next = res_status_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        o_task_next     = o_task_reg;
        o_level_next    = o_level_reg;
        o_slice_next    = o_slice_reg;
        o_alloc_next    = o_alloc_reg;
        o_yield_next    = o_yield_reg;
        o_status_next   = o_status_reg;

        sidx    = t_reg;
        lidx    = serving_reg;
        ss_we   = 1'b0;
        ss_wd   = SLOT_ALLOC;
        sl_we   = 1'b0;
        sl_wd   = lv_reg;
        sc_we   = 1'b0;
        lc_we   = 1'b0;
        lc_wd   = cnt_reg;
        lp_we   = 1'b0;
        lp_wd   = pos_reg[SLOT_W-1:0];
        q_we    = 1'b0;
        q_waddr = '0;
        q_wdata = '0;
        q_raddr = '0;
        req_ready = 1'b0;

        lv4      = lraw_reg[3] ? {1'b0, slot_level_reg[t_reg]} : lraw_reg;
        runnable = slot_state_reg[t_reg] == SLOT_RUNNABLE;
        moving   = runnable && (slot_level_reg[t_reg] != lv4[LVL_W-1:0]);
        adding   = !runnable || moving;
        p_tmp    = '0;
        n_tmp    = '0;
        c_tmp    = '0;

        unique case (state_reg)
            S_INIT0:
            begin
                q_we       = 1'b1;
                q_waddr    = '0;
                q_wdata    = '0;
                state_next = S_INIT1;
            end
            S_INIT1:
            begin
                q_we       = 1'b1;
                q_waddr    = {LVL_W'(NUM_LEVELS - 1), SLOT_W'(0)};
                q_wdata    = SLOT_W'(1);
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    op_next         = op_t'(operation);
                    t_next          = task_id;
                    lraw_next       = target_level;
                    slice_next      = time_slice;
                    idx_next        = '0;
                    res_slice_next  = '0;
                    res_alloc_next  = '0;
                    res_yield_next  = 1'b0;
                    res_status_next = STAT_OK;
                    unique case (op_t'(operation))
                        OP_ALLOC:  state_next = S_ALLOC;
                        OP_RUN:    state_next = S_RUN;
                        OP_SLEEP:  state_next = S_SLP1;
                        OP_SWITCH: state_next = S_SW1;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_ALLOC:
            begin
                sidx = idx_reg[SLOT_W-1:0];
                if (slot_state_reg[sidx] == SLOT_FREE)
                begin
                    ss_we          = 1'b1;
                    ss_wd          = SLOT_ALLOC;
                    res_alloc_next = idx_reg[SLOT_W-1:0];
                    state_next     = S_DONE;
                end
                else if (idx_reg == CNT_W'(NUM_SLOTS - 1))
                begin
                    res_status_next = STAT_NO_SLOT;
                    state_next      = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_RUN:
            begin
                lidx = lv4[LVL_W-1:0];
                if (({1'b0, t_reg} >= CNT_W'(NUM_SLOTS)) || (lv4 >= 4'(NUM_LEVELS)))
                begin
                    res_status_next = STAT_IGNORED;
                    state_next      = S_DONE;
                end
                else if (adding && (level_count_reg[lidx] >= CNT_W'(NUM_SLOTS)))
                begin
                    res_status_next = STAT_FULL;
                    state_next      = S_DONE;
                end
                else
                begin
                    sc_we        = slice_reg != '0;
                    recheck_next = 1'b1;
                    lv_next      = lv4[LVL_W-1:0];
                    ret_enq_next = 1'b1;
                    if (moving)
                    begin
                        state_next = S_DQ0;
                    end
                    else if (adding)
                    begin
                        state_next = S_ENQ;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DQ0:
            begin
                lidx       = slot_level_reg[t_reg];
                dq_lv_next = lidx;
                cnt_next   = level_count_reg[lidx];
                pos_next   = {1'b0, level_pos_reg[lidx]};
                ss_we      = 1'b1;
                ss_wd      = SLOT_ALLOC;
                idx_next   = '0;
                state_next = S_DQ_RD;
            end
            S_DQ_RD:
            begin
                if (idx_reg < cnt_reg)
                begin
                    q_raddr    = {dq_lv_reg, idx_reg[SLOT_W-1:0]};
                    state_next = S_DQ_CMP;
                end
                else
                begin
                    state_next = ret_enq_reg ? S_ENQ : S_SLP3;
                end
            end
            S_DQ_CMP:
            begin
                if (q_rdata == t_reg)
                begin
                    c_tmp = cnt_reg - 1'b1;
                    p_tmp = (idx_reg < pos_reg) ? pos_reg - 1'b1 : pos_reg;
                    if (p_tmp >= c_tmp)
                    begin
                        p_tmp = '0;
                    end
                    cnt_next   = c_tmp;
                    pos_next   = p_tmp;
                    state_next = S_SH_RD;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_DQ_RD;
                end
            end
            S_SH_RD:
            begin
                n_tmp = idx_reg + 1'b1;
                if (idx_reg < cnt_reg)
                begin
                    q_raddr    = {dq_lv_reg, n_tmp[SLOT_W-1:0]};
                    state_next = S_SH_WR;
                end
                else
                begin
                    lidx       = dq_lv_reg;
                    lc_we      = 1'b1;
                    lc_wd      = cnt_reg;
                    lp_we      = 1'b1;
                    lp_wd      = pos_reg[SLOT_W-1:0];
                    state_next = ret_enq_reg ? S_ENQ : S_SLP3;
                end
            end
            S_SH_WR:
            begin
                q_we       = 1'b1;
                q_waddr    = {dq_lv_reg, idx_reg[SLOT_W-1:0]};
                q_wdata    = q_rdata;
                idx_next   = idx_reg + 1'b1;
                state_next = S_SH_RD;
            end
            S_ENQ:
            begin
                lidx  = lv_reg;
                c_tmp = level_count_reg[lidx];
                if (c_tmp < CNT_W'(NUM_SLOTS))
                begin
                    q_we    = 1'b1;
                    q_waddr = {lv_reg, c_tmp[SLOT_W-1:0]};
                    q_wdata = t_reg;
                    lc_we   = 1'b1;
                    lc_wd   = c_tmp + 1'b1;
                end
                ss_we      = 1'b1;
                ss_wd      = SLOT_RUNNABLE;
                sl_we      = 1'b1;
                sl_wd      = lv_reg;
                state_next = S_DONE;
            end
            S_SLP1:
            begin
                if (({1'b0, t_reg} >= CNT_W'(NUM_SLOTS)) || !runnable)
                begin
                    res_status_next = STAT_IGNORED;
                    state_next      = S_DONE;
                end
                else
                begin
                    q_raddr    = {serving_reg, level_pos_reg[lidx]};
                    state_next = S_SLP2;
                end
            end
            S_SLP2:
            begin
                head_task_next = q_rdata;
                ret_enq_next   = 1'b0;
                state_next     = S_DQ0;
            end
            S_SLP3:
            begin
                if (t_reg == head_task_reg)
                begin
                    serving_next   = best_level;
                    recheck_next   = 1'b0;
                    res_yield_next = 1'b1;
                end
                state_next = S_DONE;
            end
            S_SW1:
            begin
                c_tmp = level_count_reg[lidx];
                p_tmp = {1'b0, level_pos_reg[lidx]} + 1'b1;
                n_tmp = p_tmp + 1'b1;
                if (p_tmp >= c_tmp)
                begin
                    p_tmp = '0;
                end
                if (n_tmp >= c_tmp)
                begin
                    n_tmp = '0;
                end
                lp_we   = 1'b1;
                lp_wd   = p_tmp[SLOT_W-1:0];
                nx_next = n_tmp;
                if (recheck_reg)
                begin
                    serving_next = best_level;
                    recheck_next = 1'b0;
                end
                state_next = S_SW2;
            end
            S_SW2:
            begin
                if (nx_reg >= level_count_reg[lidx])
                begin
                    nx_next = '0;
                end
                q_raddr    = {serving_reg, level_pos_reg[lidx]};
                state_next = S_SW3;
            end
            S_SW3:
            begin
                running_next = q_rdata;
                q_raddr      = {serving_reg, nx_reg[SLOT_W-1:0]};
                state_next   = S_SW4;
            end
            S_SW4:
            begin
                sidx           = q_rdata;
                res_slice_next = slot_slice_reg[sidx];
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    o_task_next    = running_reg;
                    o_level_next   = serving_reg;
                    o_slice_next   = res_slice_reg;
                    o_alloc_next   = res_alloc_reg;
                    o_yield_next   = res_yield_reg;
                    o_status_next  = res_status_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp_valid     = rsp_valid_reg;
    assign current_task  = o_task_reg;
    assign current_level = o_level_reg;
    assign next_slice    = o_slice_reg;
    assign alloc_slot    = o_alloc_reg;
    assign yield_request = o_yield_reg;
    assign status        = o_status_reg;

    logic count_over;
    always_comb
    begin
        count_over = 1'b0;
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            if (level_count_reg[i] > CNT_W'(NUM_SLOTS))
            begin
                count_over = 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n) !count_over)
        else $error("level count above slot count");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("item taken while another is in work");

    a_ignored_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (status == STAT_IGNORED)) |-> ((alloc_slot == '0) && !yield_request))
        else $error("ignored item carries a result");

    a_yield_sleep: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && yield_request) |-> (status == STAT_OK) && (next_slice == '0))
        else $error("yield outside a successful sleep");

endmodule
